[hdl/nd_index_stepper_assert.svh]
// Assertion macros for the index stepper.
// Needs clk and rst_n in scope where the macros are used.
`ifndef ND_INDEX_STEPPER_ASSERT_SVH
`define ND_INDEX_STEPPER_ASSERT_SVH

// same-cycle implication
`define NDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nd_index_stepper: check failed");

// next-cycle implication
`define NDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nd_index_stepper: check failed");

`endif

[hdl/nds_pkg.sv]
// Shared types and constants of the index stepper.
// No dependencies.
package nds_pkg;

  localparam int unsigned MAX_DIMS  = 4;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned STEP_IN_W = 32;
  // carries grow by at most one bit per dimension
  localparam int unsigned NUM_W     = STEP_IN_W + MAX_DIMS;
  localparam int unsigned DIM_W     = 2;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned FLAT_W    = 64;
  localparam int unsigned CHUNKS    = FLAT_W / SIZE_W;
  localparam int unsigned CH_W      = $clog2(CHUNKS);
  localparam int unsigned DCNT_W    = $clog2(NUM_W);
  localparam int unsigned RIDX_W    = 3;

  typedef enum logic [1:0] {
    K_ADVANCE = 2'd0,
    K_RECEDE  = 2'd1,
    K_REWIND  = 2'd2,
    K_JUMPEND = 2'd3
  } kind_t;

  localparam logic [RIDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [RIDX_W-1:0] REG_SIZE_0    = 3'd1;
  localparam logic [RIDX_W-1:0] REG_SIZE_1    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_SIZE_2    = 3'd3;
  localparam logic [RIDX_W-1:0] REG_SIZE_3    = 3'd4;

  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           target_dim;
    logic [STEP_IN_W-1:0] step;
  } in_item_t;

  typedef struct packed {
    logic [FLAT_W-1:0] flat_index;
    logic              at_start;
    logic              at_end;
    logic              bad_dim;
    logic [SIZE_W-1:0] offset_0;
    logic [SIZE_W-1:0] offset_1;
    logic [SIZE_W-1:0] offset_2;
    logic [SIZE_W-1:0] offset_3;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic apply;
    logic flat_init;
    logic flat_step;
    logic out_load;
    logic cfg_we;
  } ctl_cmd_t;

  typedef struct packed {
    logic resolve;
    logic div_last;
    logic flat_last;
    logic out_free;
  } ctl_stat_t;

  // a size of zero behaves as one
  function automatic logic [SIZE_W-1:0] extent(input logic [SIZE_W-1:0] s);
    extent = (s == '0) ? SIZE_W'(1) : s;
  endfunction

endpackage

[hdl/nds_dpath.sv]
// Datapath of the index stepper: offsets, size registers, shared divider,
// flat index accumulator and result register. Uses nds_pkg.
module nds_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nds_pkg::ctl_cmd_t            cmd,
  output nds_pkg::ctl_stat_t           stat,
  input  nds_pkg::in_item_t            in_data,
  input  logic [nds_pkg::RIDX_W-1:0]   cfg_index,
  input  logic [nds_pkg::SIZE_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nds_pkg::out_item_t           out_data
);

  localparam int unsigned SW = nds_pkg::SIZE_W;
  localparam int unsigned NW = nds_pkg::NUM_W;
  localparam int unsigned FW = nds_pkg::FLAT_W;
  localparam int unsigned MD = nds_pkg::MAX_DIMS;

  logic [nds_pkg::CNT_W-1:0]  dim_cnt_r;
  logic [SW-1:0]              size_r [MD];
  logic [SW-1:0]              pos_r  [MD];
  logic [SW-1:0]              pos_nxt[MD];
  logic [1:0]                 kind_r;
  logic                       bad_r;
  logic [nds_pkg::DIM_W-1:0]  cur_d_r;
  logic [NW-1:0]              step_r;
  logic [NW-1:0]              num_r;
  logic [SW-1:0]              rem_r;
  logic [nds_pkg::DCNT_W-1:0] div_cnt_r;
  logic [FW-1:0]              flat_r;
  logic [FW-1:0]              acc_r;
  logic [nds_pkg::DIM_W-1:0]  fi_r;
  logic [nds_pkg::CH_W-1:0]   ch_r;
  logic                       out_valid_r;
  nds_pkg::out_item_t         out_r;

  logic [nds_pkg::CNT_W-1:0]  n_dims;
  logic [nds_pkg::DIM_W-1:0]  nlast;
  logic [SW-1:0]              cur_s;
  logic [SW-1:0]              pos_cur;
  logic [NW-1:0]              sum;
  logic                       adv_fits;
  logic                       rec_fits;
  logic [SW:0]                trial;
  logic                       ge;
  logic [SW-1:0]              fs;
  logic [SW-1:0]              chunk;
  logic [2*SW-1:0]            prod;
  logic [FW-1:0]              shifted;
  logic [FW-1:0]              acc_sum;
  logic                       start_f;
  logic                       end_f;
  logic [SW-1:0]              offs[MD];
  logic [nds_pkg::DIM_W-1:0]  sidx;

  always_comb begin
    if (dim_cnt_r == '0) begin
      n_dims = nds_pkg::CNT_W'(1);
    end else if (dim_cnt_r > nds_pkg::CNT_W'(MD)) begin
      n_dims = nds_pkg::CNT_W'(MD);
    end else begin
      n_dims = dim_cnt_r;
    end
  end

  assign nlast    = nds_pkg::DIM_W'(n_dims - nds_pkg::CNT_W'(1));
  assign cur_s    = nds_pkg::extent(size_r[cur_d_r]);
  assign pos_cur  = pos_r[cur_d_r];
  assign sum      = NW'(pos_cur) + step_r;
  assign adv_fits = sum < NW'(cur_s);
  assign rec_fits = step_r <= NW'(pos_cur);

  // restoring divide, one quotient bit a cycle
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, cur_s};

  assign fs      = nds_pkg::extent(size_r[fi_r]);
  assign chunk   = flat_r[ch_r*SW +: SW];
  assign prod    = chunk * fs;
  assign shifted = FW'(prod) << (ch_r * SW);
  assign acc_sum = ((ch_r == '0) ? FW'(pos_r[fi_r]) : acc_r) + shifted;

  assign sidx = nds_pkg::DIM_W'(cfg_index - nds_pkg::REG_SIZE_0);

  always_comb begin
    stat.resolve = bad_r
                || (kind_r == nds_pkg::K_REWIND) || (kind_r == nds_pkg::K_JUMPEND)
                || ((kind_r == nds_pkg::K_ADVANCE) && (adv_fits || cur_d_r == '0))
                || ((kind_r == nds_pkg::K_RECEDE) && (rec_fits || cur_d_r == '0));
    stat.div_last  = div_cnt_r == nds_pkg::DCNT_W'(NW - 1);
    stat.flat_last = (fi_r == nlast) && (ch_r == nds_pkg::CH_W'(nds_pkg::CHUNKS - 1));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    for (int i = 0; i < MD; i++) begin
      pos_nxt[i] = pos_r[i];
    end
    if (cmd.cfg_we) begin
      case (cfg_index) inside
        nds_pkg::REG_DIM_COUNT, nds_pkg::REG_SIZE_0, nds_pkg::REG_SIZE_1,
        nds_pkg::REG_SIZE_2, nds_pkg::REG_SIZE_3: begin
          for (int i = 0; i < MD; i++) pos_nxt[i] = '0;
        end
        default: ;
      endcase
    end else if (cmd.eval && !bad_r) begin
      case (kind_r)
        nds_pkg::K_ADVANCE: begin
          if (adv_fits) begin
            pos_nxt[cur_d_r] = sum[SW-1:0];
          end else if (cur_d_r == '0) begin
            for (int i = 0; i < MD; i++) begin
              if (i < nlast) pos_nxt[i] = nds_pkg::extent(size_r[i]) - SW'(1);
              else if (i == nlast) pos_nxt[i] = nds_pkg::extent(size_r[i]);
              else pos_nxt[i] = '0;
            end
          end
        end
        nds_pkg::K_RECEDE: begin
          if (rec_fits) begin
            pos_nxt[cur_d_r] = pos_cur - step_r[SW-1:0];
          end else if (cur_d_r == '0) begin
            for (int i = 0; i < MD; i++) pos_nxt[i] = '0;
          end
        end
        nds_pkg::K_REWIND: begin
          for (int i = 0; i < MD; i++) pos_nxt[i] = '0;
        end
        default: begin
          for (int i = 0; i < MD; i++) begin
            if (i < nlast) pos_nxt[i] = nds_pkg::extent(size_r[i]) - SW'(1);
            else if (i == nlast) pos_nxt[i] = nds_pkg::extent(size_r[i]);
            else pos_nxt[i] = '0;
          end
        end
      endcase
    end else if (cmd.apply) begin
      if (kind_r == nds_pkg::K_ADVANCE) pos_nxt[cur_d_r] = rem_r;
      else if (rem_r == '0) pos_nxt[cur_d_r] = '0;
      else pos_nxt[cur_d_r] = cur_s - rem_r;
    end
  end

  always_comb begin
    start_f = 1'b1;
    end_f   = 1'b1;
    for (int i = 0; i < MD; i++) begin
      offs[i] = (i < n_dims) ? pos_r[i] : '0;
      if (i < n_dims) begin
        if (pos_r[i] != '0) start_f = 1'b0;
        if (i < nlast) begin
          if (pos_r[i] != nds_pkg::extent(size_r[i]) - SW'(1)) end_f = 1'b0;
        end else if (pos_r[i] != nds_pkg::extent(size_r[i])) begin
          end_f = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cnt_r   <= nds_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < MD; i++) begin
        size_r[i] <= SW'(1);
        pos_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < MD; i++) pos_r[i] <= pos_nxt[i];
      if (cmd.cfg_we) begin
        case (cfg_index) inside
          nds_pkg::REG_DIM_COUNT: dim_cnt_r <= cfg_data[nds_pkg::CNT_W-1:0];
          nds_pkg::REG_SIZE_0, nds_pkg::REG_SIZE_1, nds_pkg::REG_SIZE_2,
          nds_pkg::REG_SIZE_3: size_r[sidx] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_data.kind;
      cur_d_r <= in_data.target_dim;
      step_r  <= NW'(in_data.step);
      bad_r   <= ((in_data.kind == nds_pkg::K_ADVANCE) || (in_data.kind == nds_pkg::K_RECEDE))
              && (nds_pkg::CNT_W'(in_data.target_dim) >= n_dims);
    end
    if (cmd.eval) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
      num_r     <= (kind_r == nds_pkg::K_ADVANCE) ? sum : step_r - NW'(pos_cur);
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? SW'(trial - {1'b0, cur_s}) : trial[SW-1:0];
      num_r     <= {num_r[NW-2:0], ge};
      div_cnt_r <= div_cnt_r + nds_pkg::DCNT_W'(1);
    end
    if (cmd.apply) begin
      cur_d_r <= cur_d_r - nds_pkg::DIM_W'(1);
      if (kind_r == nds_pkg::K_RECEDE && rem_r != '0) step_r <= num_r + NW'(1);
      else step_r <= num_r;
    end
    if (cmd.flat_init) begin
      flat_r <= '0;
      fi_r   <= '0;
      ch_r   <= '0;
    end else if (cmd.flat_step) begin
      if (ch_r == nds_pkg::CH_W'(nds_pkg::CHUNKS - 1)) begin
        flat_r <= acc_sum;
        fi_r   <= fi_r + nds_pkg::DIM_W'(1);
        ch_r   <= '0;
      end else begin
        acc_r <= acc_sum;
        ch_r  <= ch_r + nds_pkg::CH_W'(1);
      end
    end
    if (cmd.out_load) begin
      out_r.flat_index <= flat_r;
      out_r.at_start   <= start_f;
      out_r.at_end     <= end_f;
      out_r.bad_dim    <= bad_r;
      out_r.offset_0   <= offs[0];
      out_r.offset_1   <= offs[1];
      out_r.offset_2   <= offs[2];
      out_r.offset_3   <= offs[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/nds_ctrl.sv]
// Controller of the index stepper: sequences evaluate, divide, carry,
// flat index and result phases. Uses nds_pkg and the assertion macros.
`include "nd_index_stepper_assert.svh"

module nds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  nds_pkg::ctl_stat_t  stat,
  output nds_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EVAL  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_APPLY = 6'b001000,
    ST_FLAT  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // a register beat goes first; the command beat waits for it
        in_stall   = cfg_valid;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.resolve) begin
          cmd.flat_init = 1'b1;
          state_nxt     = ST_FLAT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_FLAT: begin
        cmd.flat_step = 1'b1;
        if (stat.flat_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `NDS_ASSERT_NEXT(a_accept_evals, state_r == ST_IDLE && in_valid && !cfg_valid, state_r == ST_EVAL)
  `NDS_ASSERT_NEXT(a_div_holds, state_r == ST_DIV && !stat.div_last, state_r == ST_DIV)
  `NDS_ASSERT_NEXT(a_fin_done, state_r == ST_FIN && stat.out_free, state_r == ST_IDLE)
  `NDS_ASSERT_NOW(a_cfg_idle_only, cmd.cfg_we, state_r == ST_IDLE && !cmd.eval)

endmodule

[hdl/nd_index_stepper.sv]
// Top level of the N-dimensional index stepper.
// Joins nds_ctrl and nds_dpath; uses nds_pkg.

// One command is worked at a time. Rewind, jump to end and any step that
// needs no carry go from evaluate straight to the flat index and result
// phases. Each carry into a slower dimension runs the shared restoring
// divider and an apply step, then evaluates again. The flat index is built
// with one 16x16 multiply a cycle. A new item is taken while the previous
// result still waits in the output register.
module nd_index_stepper (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  nds_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output nds_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nds_pkg::RIDX_W-1:0]         cfg_index,
  input  logic [nds_pkg::SIZE_W-1:0]         cfg_data
);

  nds_pkg::ctl_cmd_t  cmd;
  nds_pkg::ctl_stat_t stat;

  nds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nds_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/nd_index_stepper_test.sv]
// Self-checking testbench for nd_index_stepper: directed and random commands
// over several dimension and size settings, checked against an in-bench model.
// Depends on nds_pkg and the nd_index_stepper RTL.
module nd_index_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nds_pkg::*;

  localparam logic [RIDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [RIDX_W-1:0] REG_TOP    = 3'd7;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 200;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [RIDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  nd_index_stepper DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [CNT_W-1:0]  dim_cnt;
  logic [SIZE_W-1:0] size_r [MAX_DIMS];
  longint unsigned   pos [MAX_DIMS];

  in_item_t  cmd_q [$];
  out_item_t result_q [$];
  bit in_taken, calm, failed;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned dims_used();
    if (dim_cnt == 0) return 1;
    if (dim_cnt > MAX_DIMS) return MAX_DIMS;
    return dim_cnt;
  endfunction

  function automatic longint unsigned ext_of(int unsigned d);
    return (size_r[d] == 0) ? 64'd1 : longint'(size_r[d]);
  endfunction

  task automatic clear_pos();
    for (int i = 0; i < MAX_DIMS; i++) pos[i] = 0;
  endtask

  task automatic go_end(int unsigned n);
    for (int unsigned i = 0; i + 1 < n; i++) pos[i] = ext_of(i) - 1;
    pos[n-1] = ext_of(n-1);
  endtask

  task automatic step_up(int unsigned d, longint unsigned st, int unsigned n);
    longint unsigned s, sum;
    bit done;
    done = 0;
    while (!done) begin
      s = ext_of(d);
      sum = pos[d] + st;
      if (sum < s) begin
        pos[d] = sum;
        done = 1;
      end else if (d == 0) begin
        go_end(n);
        done = 1;
      end else begin
        pos[d] = sum % s;
        st = sum / s;
        d--;
      end
    end
  endtask

  task automatic step_down(int unsigned d, longint unsigned st);
    longint unsigned s, brw;
    bit done;
    done = 0;
    while (!done) begin
      s = ext_of(d);
      if (st <= pos[d]) begin
        pos[d] -= st;
        done = 1;
      end else if (d == 0) begin
        clear_pos();
        done = 1;
      end else begin
        brw = (st - pos[d] + s - 1) / s;
        pos[d] = pos[d] + brw * s - st;
        st = brw;
        d--;
      end
    end
  endtask

  task automatic predict_step(input in_item_t it);
    out_item_t r;
    int unsigned n;
    longint unsigned flat, s;
    logic [SIZE_W-1:0] offs [MAX_DIMS];
    n = dims_used();
    r = '0;
    case (kind_t'(it.kind))
      K_ADVANCE, K_RECEDE: begin
        if (it.target_dim >= n) r.bad_dim = 1'b1;
        else if (kind_t'(it.kind) == K_ADVANCE) step_up(it.target_dim, it.step, n);
        else step_down(it.target_dim, it.step);
      end
      K_REWIND: clear_pos();
      default: go_end(n);
    endcase
    flat = 0;
    r.at_start = 1'b1;
    r.at_end = 1'b1;
    for (int unsigned i = 0; i < MAX_DIMS; i++) begin
      offs[i] = '0;
      if (i < n) begin
        s = ext_of(i);
        flat = flat * s + pos[i];
        offs[i] = pos[i][SIZE_W-1:0];
        if (pos[i] != 0) r.at_start = 1'b0;
        if (i + 1 < n ? pos[i] != s - 1 : pos[i] != s) r.at_end = 1'b0;
      end
    end
    r.flat_index = flat;
    r.offset_0 = offs[0];
    r.offset_1 = offs[1];
    r.offset_2 = offs[2];
    r.offset_3 = offs[3];
    result_q.push_back(r);
  endtask

  task automatic report(string fld, longint unsigned e, longint unsigned a);
    failed = 1;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, e, a);
  endtask

  // input driver and result-side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
      if (!in_valid || in_taken) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_data  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      if (in_taken) predict_step(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          failed = 1;
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data.flat_index !== exp_r.flat_index)
            report("flat_index", exp_r.flat_index, out_data.flat_index);
          if (out_data.at_start !== exp_r.at_start)
            report("at_start", exp_r.at_start, out_data.at_start);
          if (out_data.at_end !== exp_r.at_end)
            report("at_end", exp_r.at_end, out_data.at_end);
          if (out_data.bad_dim !== exp_r.bad_dim)
            report("bad_dim", exp_r.bad_dim, out_data.bad_dim);
          if (out_data.offset_0 !== exp_r.offset_0)
            report("offset_0", exp_r.offset_0, out_data.offset_0);
          if (out_data.offset_1 !== exp_r.offset_1)
            report("offset_1", exp_r.offset_1, out_data.offset_1);
          if (out_data.offset_2 !== exp_r.offset_2)
            report("offset_2", exp_r.offset_2, out_data.offset_2);
          if (out_data.offset_3 !== exp_r.offset_3)
            report("offset_3", exp_r.offset_3, out_data.offset_3);
        end
      end
      if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [RIDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DIM_COUNT) dim_cnt = val[CNT_W-1:0];
    else if (idx <= REG_SIZE_3) size_r[idx-1] = val;
    if (idx <= REG_SIZE_3) clear_pos();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    wait (cmd_q.size() == 0 && result_q.size() == 0 && !in_valid);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_shape(logic [SIZE_W-1:0] dc, logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                           logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3);
    settle();
    reg_write(REG_SIZE_0, s0);
    reg_write(REG_SIZE_1, s1);
    reg_write(REG_SIZE_2, s2);
    reg_write(REG_SIZE_3, s3);
    reg_write(REG_DIM_COUNT, dc);
  endtask

  function automatic in_item_t mk(kind_t k, int unsigned td, logic [STEP_IN_W-1:0] st);
    in_item_t it;
    it.kind = k;
    it.target_dim = td[DIM_W-1:0];
    it.step = st;
    return it;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return SIZE_W'($urandom_range(6, 1));
    if (p < 78) return '0;
    if (p < 86) return '1;
    return SIZE_W'($urandom());
  endfunction

  function automatic in_item_t rand_cmd();
    int unsigned p, q;
    logic [STEP_IN_W-1:0] st;
    kind_t k;
    p = $urandom_range(99);
    k = (p < 45) ? K_ADVANCE : (p < 80) ? K_RECEDE : (p < 90) ? K_REWIND : K_JUMPEND;
    q = $urandom_range(99);
    if (q < 45) st = $urandom_range(4);
    else if (q < 75) st = $urandom_range(200);
    else if (q < 93) st = $urandom();
    else st = '1;
    return mk(k, $urandom_range(3), st);
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    failed = 0;
    quiet_cycles = 0;
    dim_cnt = 1;
    for (int i = 0; i < MAX_DIMS; i++) size_r[i] = 1;
    clear_pos();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset shape first, then a four-dimensional one with a zero size
    cmd_q.push_back(mk(K_ADVANCE, 0, 32'd0));
    cmd_q.push_back(mk(K_ADVANCE, 1, 32'd3));
    set_shape(4, 3, 0, 2, 16'hFFFF);
    cmd_q.push_back(mk(K_ADVANCE, 3, 32'd0));
    cmd_q.push_back(mk(K_ADVANCE, 3, 32'd70000));
    cmd_q.push_back(mk(K_RECEDE, 3, 32'd1));
    cmd_q.push_back(mk(K_RECEDE, 2, 32'd5));
    cmd_q.push_back(mk(K_ADVANCE, 1, 32'd1));
    cmd_q.push_back(mk(K_JUMPEND, 2, 32'd0));
    // zero step from the end marker still carries and holds the marker
    cmd_q.push_back(mk(K_ADVANCE, 3, 32'd0));
    cmd_q.push_back(mk(K_ADVANCE, 0, '1));
    cmd_q.push_back(mk(K_RECEDE, 3, 32'd1));
    cmd_q.push_back(mk(K_RECEDE, 3, '1));
    cmd_q.push_back(mk(K_REWIND, 1, '1));
    cmd_q.push_back(mk(K_RECEDE, 0, 32'd1));
    // bad dimension only for advance and recede
    set_shape(2, 5, 4, 3, 3);
    cmd_q.push_back(mk(K_ADVANCE, 3, 32'd1));
    cmd_q.push_back(mk(K_RECEDE, 2, 32'd1));
    cmd_q.push_back(mk(K_JUMPEND, 3, 32'd9));
    cmd_q.push_back(mk(K_REWIND, 2, 32'd9));
    // count of zero acts as one, above the maximum as the maximum
    set_shape(0, 7, 2, 2, 2);
    cmd_q.push_back(mk(K_ADVANCE, 1, 32'd1));
    cmd_q.push_back(mk(K_ADVANCE, 0, 32'd6));
    set_shape(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cmd_q.push_back(mk(K_ADVANCE, 3, '1));
    cmd_q.push_back(mk(K_JUMPEND, 0, 32'd0));
    // unused register indexes keep the position
    settle();
    reg_write(REG_UNUSED, 16'hA5A5);
    reg_write(REG_TOP, 16'h5A5A);
    cmd_q.push_back(mk(K_RECEDE, 0, 32'd1));

    // sender holds off until every result is back
    settle();
    for (int i = 0; i < 6; i++) begin
      cmd_q.push_back(rand_cmd());
      wait (cmd_q.size() == 0 && result_q.size() == 0 && !in_valid);
      @(posedge clk);
    end

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8) set_shape(4, 1, 1, 1, 1);
      else set_shape($urandom_range(7), rand_size(), rand_size(), rand_size(), rand_size());
      if (ph == 3) begin
        settle();
        calm = 1;
      end
      for (int i = 0; i < 55; i++) cmd_q.push_back(rand_cmd());
      settle();
      calm = 0;
    end

    wait (cmd_q.size() == 0 && result_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
